>>> rtl/bsls_pkg.sv
// Shared types and codes for the bounded sequence list store.
package bsls_pkg;

    // Request codes
    localparam logic [2:0] REQ_INS_FRONT = 3'd0;
    localparam logic [2:0] REQ_INS_BACK  = 3'd1;
    localparam logic [2:0] REQ_READ      = 3'd2;
    localparam logic [2:0] REQ_WRITE     = 3'd3;
    localparam logic [2:0] REQ_SEARCH    = 3'd4;
    localparam logic [2:0] REQ_CLEAR     = 3'd5;

    // Result status codes
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_BADPOS = 2'd1;
    localparam logic [1:0] STATUS_EMPTY  = 2'd2;
    localparam logic [1:0] STATUS_FULL   = 2'd3;

    localparam int POS_BITS   = 6;
    localparam int DATA_BITS  = 32;
    localparam int COUNT_BITS = 7;

    typedef struct packed {
        logic [2:0]                  req_type;
        logic [POS_BITS-1:0]         position;
        logic signed [DATA_BITS-1:0] value;
    } bsls_req_t;

    typedef struct packed {
        logic signed [DATA_BITS-1:0] read_value;
        logic                        found;
        logic [1:0]                  status;
        logic [COUNT_BITS-1:0]       entry_count;
    } bsls_rsp_t;

endpackage

>>> rtl/bounded_sequence_list_store.sv
// Top level of the bounded sequence list store: sequencer, entry memory, result register.
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+---------------------------
//  req     | in        | req_valid / req_stall | bsls_pkg::bsls_req_t
//  rsp     | out       | rsp_valid / rsp_stall | bsls_pkg::bsls_rsp_t
//
//  Inserts, writes, clears and refused requests finish in the cycle of acceptance;
//  a read finishes once its memory read has returned registered data.
//  A search fetches the front entry and then compares entries one per cycle
//  through the single read port of the entry memory.
//  Reset clears the head pointer, the count and the control state; the entry memory
//  is not cleared and needs no clearing pass.
//  A finished result waits in a holding register while rsp_stall is high, and the
//  next request is then taken only once the result register is free again.
module bounded_sequence_list_store #(
    parameter int DEPTH      = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  bsls_pkg::bsls_req_t req_data,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output bsls_pkg::bsls_rsp_t rsp_data
);

    // Slot index width, count width, and widened forms for the fixed port fields
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > bsls_pkg::POS_BITS) ? CW : bsls_pkg::POS_BITS;
    localparam int EW = (CW > bsls_pkg::COUNT_BITS) ? CW : bsls_pkg::COUNT_BITS;
    localparam int VW = (VALUE_BITS > bsls_pkg::DATA_BITS) ? VALUE_BITS : bsls_pkg::DATA_BITS;

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         scan_slot_reg, scan_slot_next;
    logic [AW-1:0]         scan_k_reg, scan_k_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    bsls_pkg::bsls_rsp_t   res_reg, res_next;
    logic                  out_valid_reg, out_valid_next;
    bsls_pkg::bsls_rsp_t   out_data_reg, out_data_next;

    // Entry memory: one write port, one registered read port
    logic [VALUE_BITS-1:0] mem [DEPTH];
    logic [VALUE_BITS-1:0] rdata_reg;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;

    logic                  req_accept;
    logic                  out_free;
    logic                  full;
    logic                  finish;
    bsls_pkg::bsls_rsp_t   rsp_c;
    logic [WW-1:0]         pos_ext;
    logic                  pos_bad;
    logic [AW-1:0]         acc_offset;
    logic [AW-1:0]         acc_slot;
    logic [AW-1:0]         step_slot;
    logic [AW-1:0]         head_dec;
    logic [VW-1:0]         in_wide;
    logic [VW-1:0]         rdata_wide;
    logic [VW-1:0]         val_wide;
    logic [EW-1:0]         count_wide;
    logic                  scan_last;

    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_valid  = out_valid_reg;
    assign rsp_data   = out_data_reg;

    // The result register is free when empty or when its transaction completes now
    assign out_free = !out_valid_reg || !rsp_stall;

    assign full     = (count_reg >= CW'(DEPTH));
    assign pos_ext  = WW'(req_data.position);
    assign pos_bad  = (pos_ext >= WW'(count_reg));
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);

    // Values are held at VALUE_BITS; port fields are fixed at 32 bits
    assign in_wide    = VW'($unsigned(req_data.value));
    assign rdata_wide = VW'(rdata_reg);
    assign val_wide   = VW'(val_reg);
    assign scan_last  = ((CW'(scan_k_reg) + CW'(1)) == count_reg);

    // Offset into the list: the tail for an insert at the back, else the position
    assign acc_offset = (req_data.req_type == bsls_pkg::REQ_INS_BACK) ?
                        count_reg[AW-1:0] : pos_ext[AW-1:0];

    bsls_slot #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_acc_slot (
        .base   (head_reg),
        .offset (acc_offset),
        .slot   (acc_slot)
    );

    bsls_slot #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_step_slot (
        .base   (scan_slot_reg),
        .offset (AW'(1)),
        .slot   (step_slot)
    );

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        scan_slot_next = scan_slot_reg;
        scan_k_next    = scan_k_reg;
        val_next       = val_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = acc_slot;
        mem_wdata      = in_wide[VALUE_BITS-1:0];
        mem_re         = 1'b0;
        mem_raddr      = acc_slot;
        finish         = 1'b0;
        rsp_c          = '0;
        rsp_c.status   = bsls_pkg::STATUS_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    val_next = in_wide[VALUE_BITS-1:0];
                    finish   = 1'b1;
                    case (req_data.req_type)
                        bsls_pkg::REQ_INS_FRONT:
                        begin
                            if (full)
                            begin
                                rsp_c.status = bsls_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = head_dec;
                                head_next  = head_dec;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        bsls_pkg::REQ_INS_BACK:
                        begin
                            if (full)
                            begin
                                rsp_c.status = bsls_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        bsls_pkg::REQ_READ:
                        begin
                            if (pos_bad)
                            begin
                                rsp_c.status = bsls_pkg::STATUS_BADPOS;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                finish     = 1'b0;
                                state_next = S_READ;
                            end
                        end
                        bsls_pkg::REQ_WRITE:
                        begin
                            if (pos_bad)
                            begin
                                rsp_c.status = bsls_pkg::STATUS_BADPOS;
                            end
                            else
                            begin
                                mem_we = 1'b1;
                            end
                        end
                        bsls_pkg::REQ_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_c.status = bsls_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                // Fetch the front entry; compare from the next cycle on
                                mem_re         = 1'b1;
                                mem_raddr      = head_reg;
                                scan_slot_next = head_reg;
                                scan_k_next    = '0;
                                finish         = 1'b0;
                                state_next     = S_SCAN;
                            end
                        end
                        bsls_pkg::REQ_CLEAR:
                        begin
                            head_next  = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                rsp_c.read_value = rdata_wide[bsls_pkg::DATA_BITS-1:0];
                finish           = 1'b1;
            end
            S_SCAN:
            begin
                if (rdata_reg == val_reg)
                begin
                    rsp_c.read_value = val_wide[bsls_pkg::DATA_BITS-1:0];
                    rsp_c.found      = 1'b1;
                    finish           = 1'b1;
                end
                else if (scan_last)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    // Advance to the next entry
                    mem_re         = 1'b1;
                    mem_raddr      = step_slot;
                    scan_slot_next = step_slot;
                    scan_k_next    = scan_k_reg + AW'(1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        count_wide        = EW'(count_next);
        rsp_c.entry_count = count_wide[bsls_pkg::COUNT_BITS-1:0];

        // Send the result straight out when the register is free, else hold it
        if (finish)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_data_next  = rsp_c;
                state_next     = S_IDLE;
            end
            else
            begin
                res_next   = rsp_c;
                state_next = S_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_slot_reg <= scan_slot_next;
        scan_k_reg    <= scan_k_next;
        val_reg       <= val_next;
        res_reg       <= res_next;
        out_data_reg  <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && rsp_stall) |=> (state_reg == S_DONE))
        else $error("held result left while result register busy");

    a_scan_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CW'(scan_k_reg) < count_reg))
        else $error("search ran past the last entry");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_accept && req_data.req_type == bsls_pkg::REQ_INS_BACK && !full)
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert at back did not grow the list");

    a_result_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && out_free) |=> out_valid_reg)
        else $error("finished transaction not presented");
`endif

endmodule

>>> rtl/bsls_slot.sv
// Circular slot arithmetic: base plus offset, wrapped at the store depth.
module bsls_slot #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic [AW-1:0] base,
    input  logic [AW-1:0] offset,
    output logic [AW-1:0] slot
);

    logic [AW:0] sum;

    always_comb
    begin
        sum = {1'b0, base} + {1'b0, offset};
        // Both operands stay below DEPTH, so one subtraction is enough
        if (sum >= (AW+1)'(DEPTH))
        begin
            sum = sum - (AW+1)'(DEPTH);
        end
        slot = sum[AW-1:0];
    end

endmodule

>>> dv/tb.sv
// Self-checking testbench for the bounded sequence list store.
module tb;

    // Capacity of the block as instanced (default parameters)
    localparam int LIST_DEPTH = 64;

    // Spacing of the drain after the last expected result: longer than a
    // full-list search of LIST_DEPTH entries, with a margin over that.
    localparam int SETTLE_CYCLES = 80;

    // Request codes the block leaves undefined; they must not touch the list
    localparam logic [2:0] REQ_SPARE_LO = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    bsls_pkg::bsls_req_t req_data = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    bsls_pkg::bsls_rsp_t rsp_data;

    bounded_sequence_list_store dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow copy of the list: circular slots, front slot and length.
    // Slots only ever get read while live, and a live slot has always been
    // written by an insert or a write first.
    // ------------------------------------------------------------------
    logic signed [bsls_pkg::DATA_BITS-1:0] list_slots [LIST_DEPTH];
    logic [bsls_pkg::POS_BITS-1:0]         front_slot = '0;
    logic [bsls_pkg::COUNT_BITS-1:0]       list_len = '0;

    // Results still owed by the block, oldest first
    bsls_pkg::bsls_rsp_t expected_rsp_q [$];

    // Percentages of cycles in which the sender idles / the receiver stalls
    int idle_pct  = 0;
    int stall_pct = 0;

    int error_count = 0;
    int n_sent      = 0;
    int n_checked   = 0;
    int n_refused   = 0;
    int n_badpos    = 0;
    int n_empty     = 0;
    int n_hits      = 0;

    // Apply one request to the shadow list and return the result it owes.
    function automatic bsls_pkg::bsls_rsp_t predict_list_op(input bsls_pkg::bsls_req_t rq);
        bsls_pkg::bsls_rsp_t           rs;
        logic [bsls_pkg::POS_BITS-1:0] slot;
        int                            k;
        rs = '0;
        case (rq.req_type)
            bsls_pkg::REQ_INS_FRONT:
                if (list_len >= LIST_DEPTH)
                begin
                    rs.status = bsls_pkg::STATUS_FULL;
                    n_refused++;
                end
                else
                begin
                    // step the front back one slot, wrapping below zero
                    front_slot = front_slot - 1'b1;
                    list_slots[front_slot] = rq.value;
                    list_len++;
                end
            bsls_pkg::REQ_INS_BACK:
                if (list_len >= LIST_DEPTH)
                begin
                    rs.status = bsls_pkg::STATUS_FULL;
                    n_refused++;
                end
                else
                begin
                    slot = front_slot + list_len[bsls_pkg::POS_BITS-1:0];
                    list_slots[slot] = rq.value;
                    list_len++;
                end
            bsls_pkg::REQ_READ:
                if (rq.position >= list_len)
                begin
                    rs.status = bsls_pkg::STATUS_BADPOS;
                    n_badpos++;
                end
                else
                begin
                    slot = front_slot + rq.position;
                    rs.read_value = list_slots[slot];
                end
            bsls_pkg::REQ_WRITE:
                if (rq.position >= list_len)
                begin
                    rs.status = bsls_pkg::STATUS_BADPOS;
                    n_badpos++;
                end
                else
                begin
                    slot = front_slot + rq.position;
                    list_slots[slot] = rq.value;
                end
            bsls_pkg::REQ_SEARCH:
                if (list_len == 0)
                begin
                    rs.status = bsls_pkg::STATUS_EMPTY;
                    n_empty++;
                end
                else
                begin
                    // scan from the front; stop at the first equal entry
                    for (k = 0; k < list_len && !rs.found; k++)
                    begin
                        slot = front_slot + bsls_pkg::POS_BITS'(k);
                        if (list_slots[slot] == rq.value)
                        begin
                            rs.found      = 1'b1;
                            rs.read_value = rq.value;
                        end
                    end
                    if (rs.found)
                        n_hits++;
                end
            bsls_pkg::REQ_CLEAR:
            begin
                front_slot = '0;
                list_len   = '0;
            end
            default:
                ; // unused codes: nothing changes
        endcase
        rs.entry_count = list_len;
        return rs;
    endfunction

    function automatic bsls_pkg::bsls_req_t make_req(
        input logic [2:0]                            code,
        input logic [bsls_pkg::POS_BITS-1:0]         pos,
        input logic signed [bsls_pkg::DATA_BITS-1:0] val);
        bsls_pkg::bsls_req_t rq;
        rq.req_type = code;
        rq.position = pos;
        rq.value    = val;
        return rq;
    endfunction

    // Mostly uniform 32-bit values, with the corner values mixed in.
    function automatic logic signed [bsls_pkg::DATA_BITS-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -32'sd1;
            4:       return 32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Build one random request shaped by the shadow list: mostly positions
    // inside the list and search keys drawn from it, so that the list fills
    // up, wraps and gets scanned deep, with a share of misses and junk codes.
    function automatic bsls_pkg::bsls_req_t random_list_req();
        bsls_pkg::bsls_req_t           rq;
        int                            roll;
        logic [bsls_pkg::POS_BITS-1:0] slot;
        roll = $urandom_range(0, 999);
        rq.value = pick_value();
        if (list_len != 0 && $urandom_range(0, 4) != 0)
            rq.position = bsls_pkg::POS_BITS'($urandom_range(0, list_len - 1));
        else
            rq.position = bsls_pkg::POS_BITS'($urandom_range(0, LIST_DEPTH - 1));
        if (roll < 7)
            rq.req_type = bsls_pkg::REQ_CLEAR;
        else if (roll < 27)
            rq.req_type = ($urandom_range(0, 1) != 0) ? REQ_SPARE_LO : REQ_SPARE_HI;
        else if (roll < 250)
            rq.req_type = bsls_pkg::REQ_INS_FRONT;
        else if (roll < 480)
            rq.req_type = bsls_pkg::REQ_INS_BACK;
        else if (roll < 650)
            rq.req_type = bsls_pkg::REQ_READ;
        else if (roll < 800)
            rq.req_type = bsls_pkg::REQ_WRITE;
        else
        begin
            rq.req_type = bsls_pkg::REQ_SEARCH;
            if (list_len != 0 && $urandom_range(0, 2) != 0)
            begin
                slot = front_slot + bsls_pkg::POS_BITS'($urandom_range(0, list_len - 1));
                rq.value = list_slots[slot];
            end
        end
        return rq;
    endfunction

    // ------------------------------------------------------------------
    // Request side: offer one transaction, hold it until accepted, then
    // record what the block owes for it. Valid is only lowered for an idle gap
    // or a drain, so back-to-back transactions keep it high.
    // ------------------------------------------------------------------
    task automatic send_req(input bsls_pkg::bsls_req_t rq);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct)
                @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= rq;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        expected_rsp_q.push_back(predict_list_op(rq));
        n_sent++;
    endtask

    // Drop valid, wait for every owed result, then let a full scan's worth
    // of cycles pass so nothing stray can still come out.
    task automatic drain_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Response side: random stall, and a check of every accepted result
    // against the oldest expectation. Values are sampled at the edge, before
    // any nonblocking update of that step lands.
    // ------------------------------------------------------------------
    always @(posedge clk)
        rsp_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin : rsp_checker
        bsls_pkg::bsls_rsp_t want;
        if (rst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            n_checked++;
            if (expected_rsp_q.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result: value %0d found %b status %0d count %0d",
                             rsp_data.read_value, rsp_data.found, rsp_data.status,
                             rsp_data.entry_count);
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                if (rsp_data.read_value !== want.read_value || rsp_data.found !== want.found
                    || rsp_data.status !== want.status
                    || rsp_data.entry_count !== want.entry_count)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("result %0d: expected value %0d found %b status %0d count %0d",
                                 n_checked, want.read_value, want.found, want.status,
                                 want.entry_count);
                        $display("    got value %0d found %b status %0d count %0d",
                                 rsp_data.read_value, rsp_data.found, rsp_data.status,
                                 rsp_data.entry_count);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Searches, reads, writes and a clear on an empty list, plus the unused codes.
    task automatic test_empty_list();
        send_req(make_req(bsls_pkg::REQ_SEARCH, '0, 32'sd5));
        send_req(make_req(bsls_pkg::REQ_READ, '0, '0));
        send_req(make_req(bsls_pkg::REQ_WRITE, '0, 32'sh7fff_ffff));
        send_req(make_req(REQ_SPARE_LO, '0, '0));
        send_req(make_req(REQ_SPARE_HI, '1, -32'sd1));
        send_req(make_req(bsls_pkg::REQ_CLEAR, '1, '0));
        drain_results();
    endtask

    // Inserts at both ends (the front one wraps the head below slot zero),
    // reads and writes either side of the count, and search hit and miss.
    task automatic test_access_and_search();
        send_req(make_req(bsls_pkg::REQ_INS_FRONT, '0, 32'sh8000_0000));
        send_req(make_req(bsls_pkg::REQ_INS_BACK, '0, 32'sh7fff_ffff));
        send_req(make_req(bsls_pkg::REQ_INS_FRONT, '1, -32'sd1));
        send_req(make_req(bsls_pkg::REQ_READ, 6'd0, '0));
        send_req(make_req(bsls_pkg::REQ_READ, 6'd1, '0));
        send_req(make_req(bsls_pkg::REQ_READ, 6'd2, '0));
        send_req(make_req(bsls_pkg::REQ_READ, 6'd3, '0));
        send_req(make_req(bsls_pkg::REQ_READ, '1, '0));
        send_req(make_req(bsls_pkg::REQ_WRITE, 6'd2, 32'sd1));
        send_req(make_req(bsls_pkg::REQ_WRITE, 6'd3, 32'sd9));
        send_req(make_req(bsls_pkg::REQ_READ, 6'd2, '0));
        send_req(make_req(bsls_pkg::REQ_SEARCH, '0, 32'sh8000_0000));
        send_req(make_req(bsls_pkg::REQ_SEARCH, '0, 32'sd12345));
        send_req(make_req(bsls_pkg::REQ_SEARCH, '0, -32'sd1));
        drain_results();
    endtask

    // Fill to capacity with random contents, hit the full refusal at both
    // ends, touch the last position and scan the whole list.
    task automatic test_capacity_limit();
        logic [bsls_pkg::POS_BITS-1:0] slot;
        logic [2:0]                    code;
        send_req(make_req(bsls_pkg::REQ_CLEAR, '0, '0));
        while (list_len < LIST_DEPTH)
        begin
            code = ($urandom_range(0, 1) != 0) ? bsls_pkg::REQ_INS_FRONT
                                               : bsls_pkg::REQ_INS_BACK;
            send_req(make_req(code, bsls_pkg::POS_BITS'($urandom), pick_value()));
        end
        send_req(make_req(bsls_pkg::REQ_INS_FRONT, '0, 32'sd7));
        send_req(make_req(bsls_pkg::REQ_INS_BACK, '1, -32'sd7));
        send_req(make_req(bsls_pkg::REQ_READ, '1, '0));
        send_req(make_req(bsls_pkg::REQ_WRITE, '1, 32'sh1234_5678));
        slot = front_slot + 6'd63;
        send_req(make_req(bsls_pkg::REQ_SEARCH, '0, list_slots[slot]));
        send_req(make_req(bsls_pkg::REQ_SEARCH, '0, 32'sh1234_5677));
        send_req(make_req(bsls_pkg::REQ_CLEAR, '0, '0));
        drain_results();
    endtask

    // Random traffic under one setting of sender idling and receiver stalls.
    task automatic test_random_traffic(input int idle_share, input int stall_share,
                                       input int n_items);
        idle_pct  = idle_share;
        stall_pct = stall_share;
        repeat (n_items)
            send_req(random_list_req());
        drain_results();
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_access_and_search();
        test_capacity_limit();
        test_random_traffic(0, 0, 300);
        test_random_traffic(48, 0, 300);
        test_random_traffic(0, 48, 300);
        test_random_traffic(37, 37, 300);

        $display("%0d requests sent and %0d results checked over four idle/stall mixes",
                 n_sent, n_checked);
        $display("%0d full refusals, %0d bad positions, %0d empty searches, %0d search hits",
                 n_refused, n_badpos, n_empty, n_hits);
        if (error_count == 0 && expected_rsp_q.size() == 0)
            $display("bounded_sequence_list_store: match");
        else
            $display("bounded_sequence_list_store: mismatch");
        $finish;
    end

    // Hard stop well past the slowest correct run
    initial
    begin
        #4000000;
        $display("bounded_sequence_list_store: mismatch");
        $finish;
    end

endmodule
